FILE: design/ctp_pkg.sv
// ctp_pkg: types, constants and arithmetic helpers for the 2D transform
// composer. Used by ctp_cordic, ctp_comb and compose_2d_transforms.
`default_nettype none

package ctp_pkg;

  // Number formats
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int POS_W          = 32;   // Q16.16
  localparam int SCALE_W        = 16;   // Q8.8
  localparam int ANGLE_W        = 16;   // angle field width
  localparam int REFL_W         = 2;

  // CORDIC
  localparam int CORDIC_STEPS    = 24;
  localparam int ITER_PER_STAGE  = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / ITER_PER_STAGE;
  localparam int Z_W             = 32;  // 2^32 per turn
  localparam int XY_W            = TRIG_FRAC_BITS + 3;
  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam logic signed [XY_W-1:0] CORDIC_X0 =
    XY_W'((CORDIC_GAIN_Q30 + (longint'(1) << (29 - TRIG_FRAC_BITS)))
          >> (30 - TRIG_FRAC_BITS));

  // Position datapath widths
  localparam int NEG_W   = POS_W + 1;              // child coord after negation
  localparam int LPROD_W = NEG_W + SCALE_W;        // Q.24 product
  localparam int L_W     = LPROD_W - 8;            // Q25.16 after rounding
  localparam int PROD_W  = L_W + XY_W;
  localparam int TERM_W  = PROD_W - TRIG_FRAC_BITS;
  localparam int SUM_W   = TERM_W + 2;
  localparam int SPROD_W = 2 * SCALE_W;
  localparam int SRND_W  = SPROD_W - 8;

  // Pipeline stage numbering
  localparam int STG_IN        = 0;
  localparam int STG_PROD      = 1;
  localparam int STG_ROUND     = 2;
  localparam int STG_TRIG_LAST = CORDIC_STAGES;
  localparam int STG_MUL       = STG_TRIG_LAST + 1;
  localparam int STG_SUM       = STG_TRIG_LAST + 2;
  localparam int STG_OUT       = STG_TRIG_LAST + 3;
  localparam int NUM_STAGES    = STG_OUT + 1;

  // Stream item layout, last field in the lowest bits
  typedef struct packed {
    logic        [REFL_W-1:0]  right_reflect;
    logic        [ANGLE_W-1:0] right_angle;
    logic signed [SCALE_W-1:0] right_scale_y;
    logic signed [SCALE_W-1:0] right_scale_x;
    logic signed [POS_W-1:0]   right_pos_y;
    logic signed [POS_W-1:0]   right_pos_x;
    logic        [REFL_W-1:0]  left_reflect;
    logic        [ANGLE_W-1:0] left_angle;
    logic signed [SCALE_W-1:0] left_scale_y;
    logic signed [SCALE_W-1:0] left_scale_x;
    logic signed [POS_W-1:0]   left_pos_y;
    logic signed [POS_W-1:0]   left_pos_x;
  } in_item_t;

  typedef struct packed {
    logic        [REFL_W-1:0]  world_reflect;
    logic        [ANGLE_W-1:0] world_angle;
    logic signed [SCALE_W-1:0] world_scale_y;
    logic signed [SCALE_W-1:0] world_scale_x;
    logic signed [POS_W-1:0]   world_pos_y;
    logic signed [POS_W-1:0]   world_pos_x;
  } out_item_t;

  localparam int IN_ITEM_W   = $bits(in_item_t);
  localparam int OUT_ITEM_W  = $bits(out_item_t);
  localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

  // CORDIC working set
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;   // negate both results (folded quadrant)
  } cordic_t;

  // Values that ride alongside the CORDIC
  typedef struct packed {
    logic signed [POS_W-1:0]   lpx;
    logic signed [POS_W-1:0]   lpy;
    logic signed [L_W-1:0]     lx;
    logic signed [L_W-1:0]     ly;
    logic signed [SCALE_W-1:0] wsx;
    logic signed [SCALE_W-1:0] wsy;
    logic        [ANGLE_W-1:0] wa;
    logic        [REFL_W-1:0]  refl;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_turn32(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = Z_W'(536870912);
      1:       v = Z_W'(316933406);
      2:       v = Z_W'(167458907);
      3:       v = Z_W'(85004756);
      4:       v = Z_W'(42667331);
      5:       v = Z_W'(21354465);
      6:       v = Z_W'(10679838);
      7:       v = Z_W'(5340245);
      8:       v = Z_W'(2670163);
      9:       v = Z_W'(1335087);
      10:      v = Z_W'(667544);
      11:      v = Z_W'(333772);
      12:      v = Z_W'(166886);
      13:      v = Z_W'(83443);
      14:      v = Z_W'(41722);
      15:      v = Z_W'(20861);
      16:      v = Z_W'(10430);
      17:      v = Z_W'(5215);
      18:      v = Z_W'(2608);
      19:      v = Z_W'(1304);
      20:      v = Z_W'(652);
      21:      v = Z_W'(326);
      22:      v = Z_W'(163);
      23:      v = Z_W'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

  // One rotation-mode micro-rotation; i is always a constant at the call
  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t r;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    r  = c;
    xs = $signed(c.x) >>> i;
    ys = $signed(c.y) >>> i;
    if (!c.z[Z_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_turn32(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_turn32(i);
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > $signed({{(SUM_W-POS_W){1'b0}}, 1'b0, {(POS_W-1){1'b1}}}))
      r = {1'b0, {(POS_W-1){1'b1}}};
    else if (v < $signed({{(SUM_W-POS_W){1'b1}}, 1'b1, {(POS_W-1){1'b0}}}))
      r = {1'b1, {(POS_W-1){1'b0}}};
    else
      r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SCALE_W-1:0] sat_scale(
    input logic signed [SRND_W-1:0] v);
    logic signed [SCALE_W-1:0] r;
    if (v > $signed({{(SRND_W-SCALE_W){1'b0}}, 1'b0, {(SCALE_W-1){1'b1}}}))
      r = {1'b0, {(SCALE_W-1){1'b1}}};
    else if (v < $signed({{(SRND_W-SCALE_W){1'b1}}, 1'b1, {(SCALE_W-1){1'b0}}}))
      r = {1'b1, {(SCALE_W-1){1'b0}}};
    else
      r = v[SCALE_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/compose_2d_transforms.sv
// compose_2d_transforms: top level; parent/child 2D transform composer.
// Depends on ctp_pkg, ctp_cordic and ctp_comb.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata: parent and child transform
//  out_    | out | out_tvalid/out_tready | out_tdata: composed world transform
//
// 16 register stages, one request per cycle unless the output stalls a full pipe:
// input capture, child-by-scale products, rounding, 12 CORDIC stages (two
// micro-rotations each, from stage 1 on), cos/sin products, sums, saturation.
// Every stage loads when it is empty or the stage after it moves, so bubbles
// close up while the output waits. rst_n clears only the valid bits.
`default_nettype none

module compose_2d_transforms (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // left_pos_x, left_pos_y, left_scale_x, left_scale_y, left_angle,
  // left_reflect, right_pos_x, right_pos_y, right_scale_x, right_scale_y,
  // right_angle, right_reflect, zero pad
  input  logic [ctp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // world_pos_x, world_pos_y, world_scale_x, world_scale_y, world_angle,
  // world_reflect, zero pad
  output logic [ctp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ctp_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_in;
  logic [NUM_STAGES-1:0] en;

  // A stage may load when some stage from it onwards is empty, or the output moves
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_en
    localparam logic [NUM_STAGES-1:0] LOW = NUM_STAGES'((longint'(1) << s) - 1);
    assign en[s] = out_tready | ~(&(vld_r | LOW));
  end

  assign vld_in = {vld_r[NUM_STAGES-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_in[s];
        end
      end
    end
  end

  assign in_tready  = en[STG_IN];
  assign out_tvalid = vld_r[STG_OUT];

  // Stage 0: capture
  in_item_t in_r;
  always_ff @(posedge clk) begin
    if (en[STG_IN]) begin
      in_r <= in_item_t'(in_tdata[IN_ITEM_W-1:0]);
    end
  end

  // Stage 1: scale products, angle and reflection
  typedef struct packed {
    logic signed [POS_W-1:0]   lpx;
    logic signed [POS_W-1:0]   lpy;
    logic signed [LPROD_W-1:0] px;
    logic signed [LPROD_W-1:0] py;
    logic signed [SPROD_W-1:0] sx;
    logic signed [SPROD_W-1:0] sy;
    logic        [ANGLE_W-1:0] wa;
    logic        [REFL_W-1:0]  refl;
  } prod_t;

  prod_t prod_r, prod_nxt;
  logic signed [NEG_W-1:0]   cx, cy;
  logic        [ANGLE_BITS-1:0] la, ra;
  logic                      inv;

  always_comb begin
    cx  = {in_r.right_pos_x[POS_W-1], in_r.right_pos_x};
    cy  = {in_r.right_pos_y[POS_W-1], in_r.right_pos_y};
    if (in_r.left_reflect[0]) cx = -cx;
    if (in_r.left_reflect[1]) cy = -cy;
    la  = in_r.left_angle[ANGLE_BITS-1:0];
    ra  = in_r.right_angle[ANGLE_BITS-1:0];
    inv = in_r.left_reflect[0] ^ in_r.left_reflect[1];   // odd parity mirrors rotation
    prod_nxt.lpx  = in_r.left_pos_x;
    prod_nxt.lpy  = in_r.left_pos_y;
    prod_nxt.px   = LPROD_W'(cx) * LPROD_W'(in_r.left_scale_x);
    prod_nxt.py   = LPROD_W'(cy) * LPROD_W'(in_r.left_scale_y);
    prod_nxt.sx   = SPROD_W'(in_r.left_scale_x) * SPROD_W'(in_r.right_scale_x);
    prod_nxt.sy   = SPROD_W'(in_r.left_scale_y) * SPROD_W'(in_r.right_scale_y);
    prod_nxt.wa   = ANGLE_W'(inv ? la - ra : la + ra);
    prod_nxt.refl = in_r.left_reflect ^ in_r.right_reflect;
  end

  always_ff @(posedge clk) begin
    if (en[STG_PROD]) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 2: round to Q25.16 / Q8.8, then ride along with the CORDIC
  side_t side_nxt;
  side_t side_r [STG_ROUND:STG_TRIG_LAST];
  logic signed [LPROD_W-1:0] rnd_px, rnd_py;
  logic signed [SPROD_W-1:0] rnd_sx, rnd_sy;

  always_comb begin
    rnd_px = prod_r.px + LPROD_W'(128);
    rnd_py = prod_r.py + LPROD_W'(128);
    rnd_sx = prod_r.sx + SPROD_W'(128);
    rnd_sy = prod_r.sy + SPROD_W'(128);
    side_nxt.lpx  = prod_r.lpx;
    side_nxt.lpy  = prod_r.lpy;
    side_nxt.lx   = rnd_px[LPROD_W-1:8];
    side_nxt.ly   = rnd_py[LPROD_W-1:8];
    side_nxt.wsx  = sat_scale(rnd_sx[SPROD_W-1:8]);
    side_nxt.wsy  = sat_scale(rnd_sy[SPROD_W-1:8]);
    side_nxt.wa   = prod_r.wa;
    side_nxt.refl = prod_r.refl;
  end

  always_ff @(posedge clk) begin
    if (en[STG_ROUND]) begin
      side_r[STG_ROUND] <= side_nxt;
    end
  end

  for (genvar g = STG_ROUND + 1; g <= STG_TRIG_LAST; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[g]) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  // Stages 1 .. STG_TRIG_LAST: cos/sin of parent angle
  cordic_t trig;

  ctp_cordic u_cordic (
    .clk      (clk),
    .en       (en[STG_TRIG_LAST:STG_PROD]),
    .angle    (in_r.left_angle),
    .trig_out (trig)
  );

  // Remaining stages: rotate, add, saturate
  out_item_t item;

  ctp_comb u_comb (
    .clk    (clk),
    .en_mul (en[STG_MUL]),
    .en_sum (en[STG_SUM]),
    .en_out (en[STG_OUT]),
    .side   (side_r[STG_TRIG_LAST]),
    .trig   (trig),
    .item   (item)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_ITEM_W){1'b0}}, item};

endmodule

`default_nettype wire

FILE: design/ctp_cordic.sv
// ctp_cordic: pipelined rotation-mode CORDIC giving cos/sin of the parent
// angle, ITER_PER_STAGE micro-rotations per register stage. Uses ctp_pkg.
`default_nettype none

module ctp_cordic (
  input  logic                                clk,
  input  logic [ctp_pkg::CORDIC_STAGES-1:0]   en,      // per-stage load enable
  input  logic [ctp_pkg::ANGLE_W-1:0]         angle,
  output ctp_pkg::cordic_t                    trig_out
);
  import ctp_pkg::*;

  cordic_t st_in  [CORDIC_STAGES];
  cordic_t st_nxt [CORDIC_STAGES];
  cordic_t st_r   [CORDIC_STAGES];

  logic [Z_W-1:0] a32;
  logic           fold;

  // Second and third quadrants are folded by a half turn; results negated later
  always_comb begin
    a32  = {angle[ANGLE_BITS-1:0], {(Z_W-ANGLE_BITS){1'b0}}};
    fold = a32[Z_W-1] ^ a32[Z_W-2];
    st_in[0].x   = CORDIC_X0;
    st_in[0].y   = '0;
    st_in[0].z   = fold ? {~a32[Z_W-1], a32[Z_W-2:0]} : a32;
    st_in[0].neg = fold;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      st_nxt[g] = st_in[g];
      for (int k = 0; k < ITER_PER_STAGE; k++) begin
        st_nxt[g] = cordic_step(st_nxt[g], g * ITER_PER_STAGE + k);
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign trig_out = st_r[CORDIC_STAGES-1];

endmodule

`default_nettype wire

FILE: design/ctp_comb.sv
// ctp_comb: rotates the scaled child offset by cos/sin, adds the parent
// position and saturates; three register stages. Uses ctp_pkg.
`default_nettype none

module ctp_comb (
  input  logic               clk,
  input  logic               en_mul,
  input  logic               en_sum,
  input  logic               en_out,
  input  ctp_pkg::side_t     side,
  input  ctp_pkg::cordic_t   trig,
  output ctp_pkg::out_item_t item
);
  import ctp_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] xc;
    logic signed [PROD_W-1:0] ys;
    logic signed [PROD_W-1:0] xs;
    logic signed [PROD_W-1:0] yc;
    side_t                    sd;
  } mul_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] wx;
    logic signed [SUM_W-1:0] wy;
    side_t                   sd;
  } sum_t;

  mul_t      mul_r, mul_nxt;
  sum_t      sum_r, sum_nxt;
  out_item_t item_r, item_nxt;

  logic signed [XY_W-1:0]   cs, sn;
  logic signed [PROD_W-1:0] rnd_xc, rnd_ys, rnd_xs, rnd_yc;
  logic signed [TERM_W-1:0] t_xc, t_ys, t_xs, t_yc;

  always_comb begin
    cs = trig.neg ? -trig.x : trig.x;
    sn = trig.neg ? -trig.y : trig.y;
    mul_nxt.xc = PROD_W'(side.lx) * PROD_W'(cs);
    mul_nxt.ys = PROD_W'(side.ly) * PROD_W'(sn);
    mul_nxt.xs = PROD_W'(side.lx) * PROD_W'(sn);
    mul_nxt.yc = PROD_W'(side.ly) * PROD_W'(cs);
    mul_nxt.sd = side;
  end

  // round half up, floor shift
  always_comb begin
    rnd_xc = mul_r.xc + (PROD_W'(1) <<< (TRIG_FRAC_BITS - 1));
    rnd_ys = mul_r.ys + (PROD_W'(1) <<< (TRIG_FRAC_BITS - 1));
    rnd_xs = mul_r.xs + (PROD_W'(1) <<< (TRIG_FRAC_BITS - 1));
    rnd_yc = mul_r.yc + (PROD_W'(1) <<< (TRIG_FRAC_BITS - 1));
    t_xc = rnd_xc[PROD_W-1:TRIG_FRAC_BITS];
    t_ys = rnd_ys[PROD_W-1:TRIG_FRAC_BITS];
    t_xs = rnd_xs[PROD_W-1:TRIG_FRAC_BITS];
    t_yc = rnd_yc[PROD_W-1:TRIG_FRAC_BITS];
    sum_nxt.wx = SUM_W'(mul_r.sd.lpx) + SUM_W'(t_xc) - SUM_W'(t_ys);
    sum_nxt.wy = SUM_W'(mul_r.sd.lpy) + SUM_W'(t_xs) + SUM_W'(t_yc);
    sum_nxt.sd = mul_r.sd;
  end

  always_comb begin
    item_nxt.world_pos_x   = sat_pos(sum_r.wx);
    item_nxt.world_pos_y   = sat_pos(sum_r.wy);
    item_nxt.world_scale_x = sum_r.sd.wsx;
    item_nxt.world_scale_y = sum_r.sd.wsy;
    item_nxt.world_angle   = sum_r.sd.wa;
    item_nxt.world_reflect = sum_r.sd.refl;
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      mul_r <= mul_nxt;
    end
    if (en_sum) begin
      sum_r <= sum_nxt;
    end
    if (en_out) begin
      item_r <= item_nxt;
    end
  end

  assign item = item_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for compose_2d_transforms, the fixed-point
// parent/child 2D transform composer. Depends on ctp_pkg and the design sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  localparam int     TAIL_CYCLES = 40;
  localparam longint GAIN_Q30    = 652032874;
  // arctan(2^-i) in 2^32-per-turn units
  localparam longint ATAN_TURN [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  in_item_t  nodes_pending[$];
  out_item_t world_due[$];
  int        sender_idle_pct = 0;
  int        recv_stall_pct  = 0;
  int        mismatch_count  = 0;

  always #6 clk = ~clk;

  compose_2d_transforms u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic longint round_shr(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // cos/sin of a binary angle in Q(TRIG_FRAC_BITS), 24-step rotation mode
  function automatic void angle_trig(input logic [ANGLE_W-1:0] ang,
                                     output longint cos_q, output longint sin_q);
    logic [31:0] a;
    logic        fold;
    longint      x;
    longint      y;
    longint      z;
    longint      t;
    a    = 32'(ang) << (32 - ANGLE_BITS);
    // second and third quadrants are folded by a half turn
    fold = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (fold) a = a - 32'h8000_0000;
    z = longint'($signed(a));
    x = (GAIN_Q30 + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_TURN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_TURN[i];
      end
      x = t;
    end
    cos_q = fold ? -x : x;
    sin_q = fold ? -y : y;
  endfunction

  function automatic out_item_t compose_world(input in_item_t t);
    out_item_t r;
    longint    lpx, lpy, lsx, lsy, rsx, rsy, lx, ly, c, s, wx, wy;
    logic      odd_parity;
    lpx = longint'($signed(t.left_pos_x));
    lpy = longint'($signed(t.left_pos_y));
    lsx = longint'($signed(t.left_scale_x));
    lsy = longint'($signed(t.left_scale_y));
    rsx = longint'($signed(t.right_scale_x));
    rsy = longint'($signed(t.right_scale_y));
    lx  = longint'($signed(t.right_pos_x));
    ly  = longint'($signed(t.right_pos_y));
    odd_parity = t.left_reflect[0] ^ t.left_reflect[1];
    if (t.left_reflect[0]) lx = -lx;
    if (t.left_reflect[1]) ly = -ly;
    lx = round_shr(lx * lsx, 8);
    ly = round_shr(ly * lsy, 8);
    angle_trig(t.left_angle, c, s);
    wx = lpx + round_shr(lx * c, TRIG_FRAC_BITS) - round_shr(ly * s, TRIG_FRAC_BITS);
    wy = lpy + round_shr(lx * s, TRIG_FRAC_BITS) + round_shr(ly * c, TRIG_FRAC_BITS);
    r.world_pos_x   = POS_W'(clamp_signed(wx, POS_W));
    r.world_pos_y   = POS_W'(clamp_signed(wy, POS_W));
    r.world_scale_x = SCALE_W'(clamp_signed(round_shr(lsx * rsx, 8), SCALE_W));
    r.world_scale_y = SCALE_W'(clamp_signed(round_shr(lsy * rsy, 8), SCALE_W));
    r.world_angle   = odd_parity ? t.left_angle - t.right_angle
                                 : t.left_angle + t.right_angle;
    r.world_reflect = t.left_reflect ^ t.right_reflect;
    return r;
  endfunction

  task automatic queue_node(input logic [31:0] lpx, input logic [31:0] lpy,
                            input logic [15:0] lsx, input logic [15:0] lsy,
                            input logic [15:0] la, input logic [1:0] lr,
                            input logic [31:0] rpx, input logic [31:0] rpy,
                            input logic [15:0] rsx, input logic [15:0] rsy,
                            input logic [15:0] ra, input logic [1:0] rr);
    in_item_t t;
    t.left_pos_x    = lpx;
    t.left_pos_y    = lpy;
    t.left_scale_x  = lsx;
    t.left_scale_y  = lsy;
    t.left_angle    = la;
    t.left_reflect  = lr;
    t.right_pos_x   = rpx;
    t.right_pos_y   = rpy;
    t.right_scale_x = rsx;
    t.right_scale_y = rsy;
    t.right_angle   = ra;
    t.right_reflect = rr;
    nodes_pending.push_back(t);
  endtask

  // mostly scene-like values so results are not all saturated; some raw noise
  function automatic in_item_t random_node();
    in_item_t t;
    t = IN_ITEM_W'({$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(3) != 0) begin
      t.left_pos_x    = 32'(int'($urandom_range(33554431)) - 16777216);
      t.left_pos_y    = 32'(int'($urandom_range(33554431)) - 16777216);
      t.right_pos_x   = 32'(int'($urandom_range(33554431)) - 16777216);
      t.right_pos_y   = 32'(int'($urandom_range(33554431)) - 16777216);
      t.left_scale_x  = 16'(int'($urandom_range(2047)) - 1024);
      t.left_scale_y  = 16'(int'($urandom_range(2047)) - 1024);
      t.right_scale_x = 16'(int'($urandom_range(2047)) - 1024);
      t.right_scale_y = 16'(int'($urandom_range(2047)) - 1024);
    end
    return t;
  endfunction

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $realtime, fname, want, got);
    end
  endtask

  task automatic drain_all();
    while (nodes_pending.size() != 0 || in_tvalid || world_due.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        world_due.push_back(compose_world(in_item_t'(in_tdata[IN_ITEM_W-1:0])));
      if (!in_tvalid || in_tready) begin
        if (nodes_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(nodes_pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[OUT_ITEM_W-1:0]);
        if (world_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result %h", $realtime, got);
        end else begin
          want = world_due.pop_front();
          check_field("world_pos_x", want.world_pos_x, got.world_pos_x);
          check_field("world_pos_y", want.world_pos_y, got.world_pos_y);
          check_field("world_scale_x", want.world_scale_x, got.world_scale_x);
          check_field("world_scale_y", want.world_scale_y, got.world_scale_y);
          check_field("world_angle", want.world_angle, got.world_angle);
          check_field("world_reflect", want.world_reflect, got.world_reflect);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // identity parent, then offset, scale and rotation together
    queue_node(0, 0, 16'h0100, 16'h0100, 0, 0, 32'h0001_0000, 32'h0002_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(32'h0010_0000, 32'hFFF0_0000, 16'h0200, 16'h0080, 16'h1000, 0,
               32'h0003_8000, 32'hFFFE_4000, 16'h0180, 16'hFF00, 16'h2345, 0);
    // parent reflections 1, 2 and 3, odd parity negates the child angle
    queue_node(32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'h2000, 1,
               32'h0005_0000, 32'h0007_0000, 16'h0100, 16'h0100, 16'h3000, 2);
    queue_node(32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'h6000, 2,
               32'h0005_0000, 32'h0007_0000, 16'h0100, 16'h0100, 16'h7000, 1);
    queue_node(32'h0001_0000, 32'h0002_0000, 16'h0100, 16'h0100, 16'hA000, 3,
               32'h0005_0000, 32'h0007_0000, 16'h0100, 16'h0100, 16'h1234, 3);
    // quadrant edges of the parent angle
    queue_node(0, 0, 16'h0100, 16'h0100, 16'h3FFF, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'h4000, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'h8000, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'hBFFF, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'hC000, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'hFFFF, 0, 32'h0010_0000, 32'h0008_0000,
               16'h0100, 16'h0100, 0, 0);
    // angle wrap both ways
    queue_node(0, 0, 16'h0100, 16'h0100, 16'hF000, 0, 0, 0, 16'h0100, 16'h0100,
               16'h2000, 0);
    queue_node(0, 0, 16'h0100, 16'h0100, 16'h1000, 1, 0, 0, 16'h0100, 16'h0100,
               16'h2000, 0);
    // negating the most negative child position
    queue_node(0, 0, 16'h0100, 16'h0100, 0, 3, 32'h8000_0000, 32'h8000_0000,
               16'h0100, 16'h0100, 0, 0);
    // position saturation high and low
    queue_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 0, 0,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0100, 16'h0100, 0, 0);
    queue_node(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 0, 0,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0100, 16'h0100, 0, 0);
    queue_node(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h2000, 1,
               32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'hFFFF, 2);
    // scale saturation and zero
    queue_node(0, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0);
    queue_node(0, 0, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0);
    queue_node(0, 0, 16'h0000, 16'h0001, 0, 0, 32'h1234_5678, 32'h8765_4321,
               16'h8000, 16'h0080, 0, 0);
    // all zero, all ones
    queue_node(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_node('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    drain_all();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int n = 0; n < 100; n++)
        nodes_pending.push_back(random_node());
      // sender holds off until every request has come back
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (world_due.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
design/ctp_pkg.sv
design/ctp_cordic.sv
design/ctp_comb.sv
design/compose_2d_transforms.sv
tb/tb_top.sv
